/* rtl/core/rhc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to HSV conversion unit
// Hue scaling, divider geometry and the per-stage divider record.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned PIXEL_W    = 3 * CHAN_W;
  localparam int unsigned HUE_W      = 15;
  localparam int unsigned HUE_SECTOR = 3840;
  localparam int unsigned HUE_FULL   = 6 * HUE_SECTOR;
  localparam int unsigned SAT_SCALE  = 255;

  // Restoring divider: twelve quotient bits cover the hue term (at most 3840).
  localparam int unsigned QUO_W     = 12;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned REM_W     = 20;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // One beat as it travels through the divider stages.
  typedef struct packed {
    logic [REM_W-1:0]  rem_h;
    logic [REM_W-1:0]  rem_s;
    logic [CHAN_W-1:0] den_h;
    logic [CHAN_W-1:0] den_s;
    logic [QUO_W-1:0]  quo_h;
    logic [QUO_W-1:0]  quo_s;
    sector_t           sector;
    logic              neg;
    logic [CHAN_W-1:0] max_val;
  } div_t;

  // One shift-and-subtract step for both lanes; the quotient bit weight is 2^step.
  function automatic div_t div_step(div_t cur, int unsigned step);
    div_t             nxt;
    logic [REM_W-1:0] trial_h;
    logic [REM_W-1:0] trial_s;
    nxt     = cur;
    trial_h = REM_W'(cur.den_h) << step;
    trial_s = REM_W'(cur.den_s) << step;
    if (cur.rem_h >= trial_h) begin
      nxt.rem_h = cur.rem_h - trial_h;
      nxt.quo_h = {cur.quo_h[QUO_W-2:0], 1'b1};
    end else begin
      nxt.quo_h = {cur.quo_h[QUO_W-2:0], 1'b0};
    end
    if (cur.rem_s >= trial_s) begin
      nxt.rem_s = cur.rem_s - trial_s;
      nxt.quo_s = {cur.quo_s[QUO_W-2:0], 1'b1};
    end else begin
      nxt.quo_s = {cur.quo_s[QUO_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rgb_to_hsv_convert_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_unit: pipelined RGB to HSV pixel converter
// Turns one 24-bit RGB pixel into hue (1/64 degree), saturation and value.
// ----------------------------------------------------------------------------
// The unit accepts one pixel beat on every clock while pixel_stall is low, and
// returns one result beat per pixel, in order. The two exact rounded divisions
// (hue term over chroma, scaled chroma over the largest channel) run side by
// side through a twelve-stage restoring divider, one quotient bit per stage;
// one front stage finds the extremes and the sector, one forms the rounded
// numerators, and one stage at the end adds the sector offset. The whole
// pipeline advances together: while a result beat waits with result_stall
// high, pixel_stall is raised, and nothing inside moves, so no beat is lost
// or repeated. Value is the largest channel, saturation is round(255 *
// chroma / max) and is 0 for black, and hue is 0 for any grey pixel.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          pixel_valid,
  output logic                         pixel_stall,
  input  wire  [rhc_pkg::PIXEL_W-1:0]  rgb_word,
  output logic                         result_valid,
  input  wire                          result_stall,
  output logic [rhc_pkg::HUE_W-1:0]    hue_angle,
  output logic [rhc_pkg::CHAN_W-1:0]   saturation,
  output logic [rhc_pkg::CHAN_W-1:0]   brightness
);
  import rhc_pkg::*;

  // Pipeline advance: everything moves unless the output beat is held.
  logic advance;
  assign advance     = !(result_valid && result_stall);
  assign pixel_stall = !advance;

  // ---------------------------------------------------------------- stage A
  // Largest and smallest channel, sector choice (red first, then green, then
  // blue) and the signed difference that drives the hue term.
  logic [CHAN_W-1:0] red, green, blue;
  logic [CHAN_W-1:0] max_c, min_c, diff_a, diff_b;
  sector_t           sector_c;

  assign red   = rgb_word[3*CHAN_W-1:2*CHAN_W];
  assign green = rgb_word[2*CHAN_W-1:CHAN_W];
  assign blue  = rgb_word[CHAN_W-1:0];

  always_comb begin
    max_c = red;
    min_c = red;
    if (green > max_c) max_c = green;
    if (blue > max_c)  max_c = blue;
    if (green < min_c) min_c = green;
    if (blue < min_c)  min_c = blue;
    if (max_c == red) begin
      sector_c = SECT_RED;
      diff_a   = green;
      diff_b   = blue;
    end else if (max_c == green) begin
      sector_c = SECT_GREEN;
      diff_a   = blue;
      diff_b   = red;
    end else begin
      sector_c = SECT_BLUE;
      diff_a   = red;
      diff_b   = green;
    end
  end

  logic              a_valid;
  logic [CHAN_W-1:0] a_max, a_chroma, a_mag;
  logic              a_neg;
  sector_t           a_sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_max    <= max_c;
      a_chroma <= max_c - min_c;
      a_sector <= sector_c;
      a_neg    <= diff_a < diff_b;
      a_mag    <= (diff_a >= diff_b) ? diff_a - diff_b : diff_b - diff_a;
    end
  end

  // ---------------------------------------------------------------- stage B
  // round(n / d) equals floor((n + floor(d / 2)) / d), so the rounding bias
  // is folded into the numerator and the divider only truncates.
  div_t              pipe      [DIV_STEPS+1];
  logic [DIV_STEPS:0] pipe_vld;
  div_t              load_c;

  always_comb begin
    load_c         = '0;
    load_c.rem_h   = REM_W'(a_mag) * REM_W'(HUE_SECTOR) + REM_W'(a_chroma >> 1);
    load_c.rem_s   = REM_W'(a_chroma) * REM_W'(SAT_SCALE) + REM_W'(a_max >> 1);
    load_c.den_h   = a_chroma;
    load_c.den_s   = a_max;
    load_c.sector  = a_sector;
    load_c.neg     = a_neg;
    load_c.max_val = a_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld[0] <= 1'b0;
    end else if (advance) begin
      pipe_vld[0] <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pipe[0] <= load_c;
    end
  end

  // ---------------------------------------------------------- divider stages
  // Stage i settles the quotient bit of weight 2^(DIV_STEPS-1-i).
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe_vld[i+1] <= 1'b0;
      end else if (advance) begin
        pipe_vld[i+1] <= pipe_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        pipe[i+1] <= div_step(pipe[i], DIV_STEPS - 1 - i);
      end
    end
  end

  // ------------------------------------------------------------ output stage
  // A grey pixel has zero chroma and a black one a zero maximum; the divider
  // output is meaningless then and is replaced by zero.
  div_t             fin;
  logic [HUE_W-1:0] term;
  logic [HUE_W-1:0] hue_next;
  logic [CHAN_W-1:0] sat_next;

  assign fin  = pipe[DIV_STEPS];
  assign term = HUE_W'(fin.quo_h);

  always_comb begin
    case (fin.sector)
      SECT_RED: begin
        if (!fin.neg) begin
          hue_next = term;
        end else if (term == '0) begin
          hue_next = '0;
        end else begin
          hue_next = HUE_W'(HUE_FULL) - term;
        end
      end
      SECT_GREEN: begin
        hue_next = fin.neg ? HUE_W'(2 * HUE_SECTOR) - term
                           : HUE_W'(2 * HUE_SECTOR) + term;
      end
      SECT_BLUE: begin
        hue_next = fin.neg ? HUE_W'(4 * HUE_SECTOR) - term
                           : HUE_W'(4 * HUE_SECTOR) + term;
      end
      default: begin
        hue_next = '0;
      end
    endcase
    if (fin.den_h == '0) begin
      hue_next = '0;
    end
    sat_next = (fin.den_s == '0) ? '0 : fin.quo_s[CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= pipe_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hue_angle  <= hue_next;
      saturation <= sat_next;
      brightness <= fin.max_val;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rhc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_checker: port-level checks for the RGB to HSV conversion unit
// Watches the result channel and the back-pressure path over time.
// ----------------------------------------------------------------------------
module rhc_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         pixel_stall,
  input wire                         result_valid,
  input wire                         result_stall,
  input wire [rhc_pkg::HUE_W-1:0]    hue_angle,
  input wire [rhc_pkg::CHAN_W-1:0]   saturation,
  input wire [rhc_pkg::CHAN_W-1:0]   brightness
);
  import rhc_pkg::*;

  // No result beat is shown in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat shown straight after reset");

  // A held result beat keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      result_valid && result_stall |=> result_valid && $stable(hue_angle)
        && $stable(saturation) && $stable(brightness))
    else $error("held result beat changed");

  // While a result beat is held the unit takes no new pixel.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
      result_valid && result_stall |-> pixel_stall)
    else $error("pixel taken while result held");

  // Hue stays on the circle.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
      result_valid |-> hue_angle < HUE_W'(HUE_FULL))
    else $error("hue out of range");

  // Black has no hue or saturation, and any hue implies some saturation.
  a_grey: assert property (@(posedge clk) disable iff (rst)
      result_valid && (brightness == '0 || saturation == '0) |-> hue_angle == '0)
    else $error("hue on a pixel without chroma");

endmodule

bind rgb_to_hsv_convert_unit rhc_checker u_rhc_checker (.*);
`default_nettype wire
